### sv/ppc_pkg.sv
// constants and types shared by the piecewise pressure converter
package ppc_pkg;

    localparam int SAMPLE_W   = 13;
    localparam int PRESSURE_W = 17;
    localparam int SLOPE_W    = 16;
    localparam int ICPT_W     = 27;
    localparam int PROD_W     = SLOPE_W + SAMPLE_W + 1;
    localparam int LINE_W     = PROD_W + 1;
    localparam int FRAC_DROP  = 8;
    localparam int ADDR_W     = 4;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    localparam logic [PRESSURE_W-1:0] PRESSURE_MAX = '1;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_BREAK_ONE   = 2'd0;
    localparam t_reg_idx REG_BREAK_TWO   = 2'd1;
    localparam t_reg_idx REG_BREAK_THREE = 2'd2;
    localparam t_reg_idx REG_BREAK_FOUR  = 2'd3;

    localparam logic [SAMPLE_W-1:0] BREAK_ONE_RST   = 13'd2170;
    localparam logic [SAMPLE_W-1:0] BREAK_TWO_RST   = 13'd2380;
    localparam logic [SAMPLE_W-1:0] BREAK_THREE_RST = 13'd3780;
    localparam logic [SAMPLE_W-1:0] BREAK_FOUR_RST  = 13'd4102;

    typedef logic [1:0] t_seg;

    // slopes and intercepts in q.16
    function automatic logic signed [SLOPE_W-1:0] seg_slope(input t_seg seg);
        logic signed [SLOPE_W-1:0] v;
        case (seg)
            2'd0:    v = -16'sd5600;
            2'd1:    v = -16'sd1142;
            2'd2:    v = -16'sd4364;
            default: v = -16'sd28928;
        endcase
        return v;
    endfunction

    function automatic logic signed [ICPT_W-1:0] seg_icpt(input t_seg seg);
        logic signed [ICPT_W-1:0] v;
        case (seg)
            2'd0:    v = 27'sd21819235;
            2'd1:    v = 27'sd34366715;
            2'd2:    v = 27'sd17376543;
            default: v = 27'sd11859001;
        endcase
        return v;
    endfunction

endpackage

### sv/piecewise_pressure_convert_max.sv
// top level of the piecewise pressure converter with packet peak tracking
//
// Each input word carries one 13-bit raw sample; the block maps it through a
// four-segment linear calibration (breakpoints set over the APB port) to an
// unsigned Q9.8 pressure and returns one output word per sample holding the
// pressure and the running packet maximum, with tlast copied from the input.
// A word is taken every cycle while the output register is not stalled by
// tready; the input handshake loads the input register, which feeds the
// result register through the segment select, one 16x14 multiply, add and
// saturate. The peak restarts from zero after each word marked last.
module piecewise_pressure_convert_max (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample[12:0]
    input  logic [ppc_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                           i_s_axis_tlast,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // pressure[16:0], packet_peak[33:17]
    output logic [ppc_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppc_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int SW = ppc_pkg::SAMPLE_W;
    localparam int PW = ppc_pkg::PRESSURE_W;

    logic [SW-1:0] r_break_one, r_break_two, r_break_three, r_break_four;
    logic          r_in_valid;
    logic [SW-1:0] r_in_sample;
    logic          r_in_last;
    logic          r_out_valid;
    logic [PW-1:0] r_out_pressure;
    logic [PW-1:0] r_out_peak;
    logic          r_out_last;
    logic [PW-1:0] r_peak;

    logic                                 w_out_load;
    logic                                 w_in_load;
    logic                                 w_hit;
    ppc_pkg::t_seg                        w_seg;
    logic signed [ppc_pkg::PROD_W-1:0]    w_prod;
    logic signed [ppc_pkg::LINE_W-1:0]    w_line;
    logic [ppc_pkg::LINE_W-ppc_pkg::FRAC_DROP-1:0] w_q;
    logic [PW-1:0]                        n_pressure;
    logic [PW-1:0]                        n_peak;
    ppc_pkg::t_reg_idx                    w_idx;

    // configuration port
    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_one   <= ppc_pkg::BREAK_ONE_RST;
            r_break_two   <= ppc_pkg::BREAK_TWO_RST;
            r_break_three <= ppc_pkg::BREAK_THREE_RST;
            r_break_four  <= ppc_pkg::BREAK_FOUR_RST;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                ppc_pkg::REG_BREAK_ONE:   r_break_one   <= pwdata[SW-1:0];
                ppc_pkg::REG_BREAK_TWO:   r_break_two   <= pwdata[SW-1:0];
                ppc_pkg::REG_BREAK_THREE: r_break_three <= pwdata[SW-1:0];
                ppc_pkg::REG_BREAK_FOUR:  r_break_four  <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ppc_pkg::REG_BREAK_ONE:   prdata = {{(32-SW){1'b0}}, r_break_one};
            ppc_pkg::REG_BREAK_TWO:   prdata = {{(32-SW){1'b0}}, r_break_two};
            ppc_pkg::REG_BREAK_THREE: prdata = {{(32-SW){1'b0}}, r_break_three};
            ppc_pkg::REG_BREAK_FOUR:  prdata = {{(32-SW){1'b0}}, r_break_four};
            default:                  prdata = '0;
        endcase
    end

    // handshake
    assign w_out_load      = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign w_in_load       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_in_sample <= i_s_axis_tdata[SW-1:0];
            r_in_last   <= i_s_axis_tlast;
        end
    end

    // segment select
    always_comb begin
        w_hit = 1'b1;
        w_seg = 2'd0;
        if (r_in_sample == '0) begin
            w_hit = 1'b0;
        end else if (r_in_sample <= r_break_one) begin
            w_seg = 2'd0;
        end else if (r_in_sample <= r_break_two) begin
            w_seg = 2'd1;
        end else if (r_in_sample <= r_break_three) begin
            w_seg = 2'd2;
        end else if (r_in_sample <= r_break_four) begin
            w_seg = 2'd3;
        end else begin
            w_hit = 1'b0;
        end
    end

    // line value in q.16, truncated to q9.8 with clamp and saturation
    assign w_prod = ppc_pkg::PROD_W'(ppc_pkg::seg_slope(w_seg))
                  * ppc_pkg::PROD_W'($signed({1'b0, r_in_sample}));
    assign w_line = ppc_pkg::LINE_W'(w_prod)
                  + ppc_pkg::LINE_W'(ppc_pkg::seg_icpt(w_seg));
    assign w_q    = w_line[ppc_pkg::LINE_W-1:ppc_pkg::FRAC_DROP];

    always_comb begin
        if (!w_hit || w_line <= 0) begin
            n_pressure = '0;
        end else if (w_q > (ppc_pkg::LINE_W-ppc_pkg::FRAC_DROP)'(ppc_pkg::PRESSURE_MAX)) begin
            n_pressure = ppc_pkg::PRESSURE_MAX;
        end else begin
            n_pressure = w_q[PW-1:0];
        end
        n_peak = (n_pressure > r_peak) ? n_pressure : r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_peak      <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_peak      <= r_in_last ? '0 : n_peak;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pressure <= n_pressure;
            r_out_peak     <= n_peak;
            r_out_last     <= r_in_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {{(ppc_pkg::M_TDATA_W-2*PW){1'b0}}, r_out_peak, r_out_pressure};

endmodule

### dv/piecewise_pressure_convert_max_checker.sv
`timescale 1ns / 100ps
// checker for the pressure converter: predicts every output word and compares it

module piecewise_pressure_convert_max_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample[12:0]
    input  logic [ppc_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tlast,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // pressure[16:0], packet_peak[33:17]
    input  logic [ppc_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input  logic                           i_m_tlast,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [ppc_pkg::ADDR_W-1:0]     i_paddr,
    input  logic [31:0]                    i_pwdata,
    input  logic                           i_pready,
    output int                             o_fail_count,
    output int                             o_outstanding
);

    localparam int SW = ppc_pkg::SAMPLE_W;
    localparam int PW = ppc_pkg::PRESSURE_W;

    localparam ppc_pkg::t_seg SEG_FIRST  = 2'd0;
    localparam ppc_pkg::t_seg SEG_SECOND = 2'd1;
    localparam ppc_pkg::t_seg SEG_THIRD  = 2'd2;
    localparam ppc_pkg::t_seg SEG_FOURTH = 2'd3;

    typedef struct packed {
        logic [PW-1:0] pressure;
        logic [PW-1:0] peak;
        logic          closes;
    } t_pressure_word;

    logic [SW-1:0]   brk_one;
    logic [SW-1:0]   brk_two;
    logic [SW-1:0]   brk_three;
    logic [SW-1:0]   brk_four;
    logic [PW-1:0]   running_peak;
    t_pressure_word  expected_words [$];
    t_pressure_word  want;
    logic [PW-1:0]   got_pressure;
    logic [PW-1:0]   got_peak;
    int              fail_total = 0;
    int              n_expected = 0;

    assign o_fail_count  = fail_total;
    assign o_outstanding = n_expected;

    function automatic logic [PW-1:0] calibrate_sample(input logic [SW-1:0] s);
        ppc_pkg::t_seg seg;
        longint        slope;
        longint        icpt;
        longint        line;
        longint        q;
        if (s == '0)
            return '0;
        if (s <= brk_one)
            seg = SEG_FIRST;
        else if (s <= brk_two)
            seg = SEG_SECOND;
        else if (s <= brk_three)
            seg = SEG_THIRD;
        else if (s <= brk_four)
            seg = SEG_FOURTH;
        else
            return '0;
        // q.16 coefficients, rounded to nearest
        case (seg)
            SEG_FIRST: begin
                slope = -5600;
                icpt  = 21819235;
            end
            SEG_SECOND: begin
                slope = -1142;
                icpt  = 34366715;
            end
            SEG_THIRD: begin
                slope = -4364;
                icpt  = 17376543;
            end
            default: begin
                slope = -28928;
                icpt  = 11859001;
            end
        endcase
        line = icpt + slope * longint'(s);
        if (line <= 0)
            return '0;
        q = line >>> ppc_pkg::FRAC_DROP;
        if (q > longint'(ppc_pkg::PRESSURE_MAX))
            return ppc_pkg::PRESSURE_MAX;
        return q[PW-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            brk_one      = ppc_pkg::BREAK_ONE_RST;
            brk_two      = ppc_pkg::BREAK_TWO_RST;
            brk_three    = ppc_pkg::BREAK_THREE_RST;
            brk_four     = ppc_pkg::BREAK_FOUR_RST;
            running_peak = '0;
            expected_words.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (ppc_pkg::t_reg_idx'(i_paddr[3:2]))
                    ppc_pkg::REG_BREAK_ONE:   brk_one   = i_pwdata[SW-1:0];
                    ppc_pkg::REG_BREAK_TWO:   brk_two   = i_pwdata[SW-1:0];
                    ppc_pkg::REG_BREAK_THREE: brk_three = i_pwdata[SW-1:0];
                    default:                  brk_four  = i_pwdata[SW-1:0];
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got_pressure = i_m_tdata[PW-1:0];
                got_peak     = i_m_tdata[2*PW-1:PW];
                if (expected_words.size() == 0) begin
                    $error("output word with none expected: pressure %0d peak %0d",
                           got_pressure, got_peak);
                    fail_total++;
                end else begin
                    want = expected_words.pop_front();
                    if (got_pressure !== want.pressure) begin
                        $error("pressure expected %0d got %0d", want.pressure, got_pressure);
                        fail_total++;
                    end
                    if (got_peak !== want.peak) begin
                        $error("packet_peak expected %0d got %0d", want.peak, got_peak);
                        fail_total++;
                    end
                    if (i_m_tlast !== want.closes) begin
                        $error("peak_final expected %0d got %0d", want.closes, i_m_tlast);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want.pressure = calibrate_sample(i_s_tdata[SW-1:0]);
                if (want.pressure > running_peak)
                    running_peak = want.pressure;
                want.peak   = running_peak;
                want.closes = i_s_tlast;
                if (i_s_tlast)
                    running_peak = '0;
                expected_words.push_back(want);
            end
        end
        n_expected = expected_words.size();
    end

endmodule

### dv/piecewise_pressure_convert_max_tb.sv
`timescale 1ns / 100ps
// testbench top for the pressure converter: clock, reset, stimulus and verdict

module piecewise_pressure_convert_max_tb;

    localparam int SW = ppc_pkg::SAMPLE_W;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    // sample[12:0]
    logic [ppc_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                           s_tlast = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           o_s_tready;
    // pressure[16:0], packet_peak[33:17]
    logic [ppc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tlast;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [ppc_pkg::ADDR_W-1:0]     paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    int                             fail_count;
    int                             outstanding;
    int                             src_idle_pct = 28;
    int                             sink_idle_pct = 56;
    int                             hold_requests = 0;
    logic [SW-1:0]                  breaks [4];

    piecewise_pressure_convert_max uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    piecewise_pressure_convert_max_checker pressure_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #3000000;
        $display("[piecewise_pressure_convert_max] ERROR");
        $finish;
    end

    // output side: random back-pressure plus an occasional long hold-off
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_word(input logic [SW-1:0] smp, input logic lst);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {{(ppc_pkg::S_TDATA_W-SW){1'b0}}, smp};
        s_tlast  <= lst;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!o_s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_break(input ppc_pkg::t_reg_idx idx, input logic [SW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_E000) | 32'(val);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        breaks[idx] = val;
    endtask

    task automatic set_breaks(input logic [SW-1:0] b1, input logic [SW-1:0] b2,
                              input logic [SW-1:0] b3, input logic [SW-1:0] b4);
        write_break(ppc_pkg::REG_BREAK_ONE, b1);
        write_break(ppc_pkg::REG_BREAK_TWO, b2);
        write_break(ppc_pkg::REG_BREAK_THREE, b3);
        write_break(ppc_pkg::REG_BREAK_FOUR, b4);
    endtask

    // random packets of 1 to 12 words, samples biased towards the breakpoints
    task automatic run_traffic(input int count, input bit with_hold, input bit with_pause);
        int            left;
        logic [SW-1:0] smp;
        left = 0;
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == count / 3)
                hold_requests = hold_requests + 1;
            if (with_pause && n == (2 * count) / 3)
                wait_drained();
            if (left == 0)
                left = $urandom_range(12, 1);
            left--;
            case ($urandom_range(9))
                0:       smp = '0;
                1:       smp = SW'($urandom_range(8191));
                2, 3, 4: smp = SW'(breaks[2'($urandom_range(3))] + $urandom_range(4) - 2);
                5:       smp = SW'($urandom_range(800, 1));
                default: smp = SW'($urandom_range(4500, 1));
            endcase
            send_word(smp, left == 0);
        end
    endtask

    initial begin
        int unsigned a;
        int unsigned b;
        int unsigned c;
        breaks[ppc_pkg::REG_BREAK_ONE]   = ppc_pkg::BREAK_ONE_RST;
        breaks[ppc_pkg::REG_BREAK_TWO]   = ppc_pkg::BREAK_TWO_RST;
        breaks[ppc_pkg::REG_BREAK_THREE] = ppc_pkg::BREAK_THREE_RST;
        breaks[ppc_pkg::REG_BREAK_FOUR]  = ppc_pkg::BREAK_FOUR_RST;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset breakpoints: zero, segment edges, beyond the last one
        send_word(13'd0, 1'b0);
        send_word(13'd1, 1'b0);
        send_word(13'd2170, 1'b0);
        send_word(13'd2171, 1'b1);
        send_word(13'd2380, 1'b0);
        send_word(13'd2381, 1'b0);
        send_word(13'd3780, 1'b1);
        send_word(13'd3781, 1'b1);
        send_word(13'd4102, 1'b0);
        send_word(13'd4103, 1'b0);
        send_word(13'd8191, 1'b0);
        send_word(13'd2730, 1'b1);

        // second segment from the bottom: saturation at small samples
        wait_drained();
        set_breaks(13'd0, 13'd8191, 13'd8191, 13'd8191);
        send_word(13'd1, 1'b0);
        send_word(13'd711, 1'b0);
        send_word(13'd712, 1'b0);
        send_word(13'd8191, 1'b1);

        // only the fourth segment, positive below about 410
        wait_drained();
        set_breaks(13'd0, 13'd0, 13'd0, 13'd8191);
        send_word(13'd409, 1'b0);
        send_word(13'd410, 1'b0);
        send_word(13'd5000, 1'b1);

        wait_drained();
        set_breaks(13'd8191, 13'd8191, 13'd8191, 13'd8191);
        send_word(13'd8191, 1'b0);
        send_word(13'd1, 1'b0);

        wait_drained();
        set_breaks(13'd0, 13'd0, 13'd0, 13'd0);
        send_word(13'd1, 1'b0);
        send_word(13'd8191, 1'b1);

        wait_drained();
        set_breaks(ppc_pkg::BREAK_ONE_RST, ppc_pkg::BREAK_TWO_RST,
                   ppc_pkg::BREAK_THREE_RST, ppc_pkg::BREAK_FOUR_RST);
        run_traffic(233, 1'b0, 1'b0);

        wait_drained();
        a = $urandom_range(2000, 1);
        b = a + $urandom_range(1000);
        c = b + $urandom_range(2000);
        set_breaks(SW'(a), SW'(b), SW'(c), SW'(c + $urandom_range(2000)));
        run_traffic(234, 1'b0, 1'b1);

        src_idle_pct  = 56;
        sink_idle_pct = 28;
        wait_drained();
        set_breaks(SW'($urandom_range(8191)), SW'($urandom_range(8191)),
                   SW'($urandom_range(8191)), SW'($urandom_range(8191)));
        run_traffic(233, 1'b0, 1'b0);

        wait_drained();
        set_breaks(SW'($urandom_range(400)), SW'($urandom_range(400)),
                   SW'($urandom_range(410)), SW'($urandom_range(8191)));
        run_traffic(233, 1'b0, 1'b0);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        wait_drained();
        set_breaks(13'd0, 13'd8191, SW'($urandom_range(8191)), SW'($urandom_range(8191)));
        run_traffic(234, 1'b1, 1'b0);

        wait_drained();
        a = $urandom_range(3000, 1);
        b = a + $urandom_range(500);
        c = b + $urandom_range(1500);
        set_breaks(SW'(a), SW'(b), SW'(c), SW'(c + $urandom_range(1000)));
        run_traffic(233, 1'b0, 1'b0);

        wait_drained();
        repeat (6) @(negedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[piecewise_pressure_convert_max] OK");
        end else begin
            $display("[piecewise_pressure_convert_max] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
sv/ppc_pkg.sv
sv/piecewise_pressure_convert_max.sv
dv/piecewise_pressure_convert_max_checker.sv
dv/piecewise_pressure_convert_max_tb.sv
